FILE: design/shiprrip_pkg.sv
// Shared types, constants and codes of the signature-based re-reference replacement block.
package shiprrip_pkg;

	localparam int DEF_NUM_SETS  = 1024;
	localparam int DEF_NUM_WAYS  = 16;
	localparam int DEF_SIG_BITS  = 14;
	localparam int DEF_CTR_BITS  = 3;
	localparam int DEF_RRPV_BITS = 2;

	typedef struct packed {
		logic [9:0]  set_index;
		logic        hit;
		logic [3:0]  hit_way;
		logic [47:0] pc;
	} in_item_t;

	typedef struct packed {
		logic [3:0] victim_way;
		logic       filled;
		logic       insert_distant;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_HIT    = 2'd0,
		KIND_MISS   = 2'd1,
		KIND_IGNORE = 2'd2
	} kind_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_ROW   = 6'b000100,
		ST_CTR1  = 6'b001000,
		ST_CTR2  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

FILE: design/ship_signature_rrip_replacement.sv
// Top level of the signature-based re-reference interval replacement block.
// After reset the block sweeps its set and counter memories and starts no access until
// that pass ends; up to two accesses may wait in the queue meanwhile. Accesses enter a
// two-entry queue; the back end then handles one access at a time: the set memory read,
// then for a hit a row write and a read-modify-write of the hit line's counter, and for a
// miss a read-modify-write of the evicted line's counter, a read of the new signature's
// counter and the row write. A finished result waits in an output register while the
// next access is already being processed. A hit on an out-of-range way touches no counter.
module ship_signature_rrip_replacement #(
	parameter int NUM_SETS  = shiprrip_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS  = shiprrip_pkg::DEF_NUM_WAYS,
	parameter int SIG_BITS  = shiprrip_pkg::DEF_SIG_BITS,
	parameter int CTR_BITS  = shiprrip_pkg::DEF_CTR_BITS,
	parameter int RRPV_BITS = shiprrip_pkg::DEF_RRPV_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  shiprrip_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output shiprrip_pkg::out_item_t out_data
);
	import shiprrip_pkg::*;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = $clog2(NUM_WAYS);

	logic                q_valid, q_ready;
	logic [SET_W-1:0]    q_set;
	logic [SIG_BITS-1:0] q_sig;
	logic [WAY_W-1:0]    q_way;
	kind_t               q_kind;

	shiprrip_front #(
		.NUM_SETS(NUM_SETS),
		.NUM_WAYS(NUM_WAYS),
		.SIG_BITS(SIG_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_set(q_set),
		.q_sig(q_sig),
		.q_way(q_way),
		.q_kind(q_kind)
	);

	shiprrip_back #(
		.NUM_SETS(NUM_SETS),
		.NUM_WAYS(NUM_WAYS),
		.SIG_BITS(SIG_BITS),
		.CTR_BITS(CTR_BITS),
		.RRPV_BITS(RRPV_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_set(q_set),
		.q_sig(q_sig),
		.q_way(q_way),
		.q_kind(q_kind),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

FILE: design/shiprrip_front.sv
// Front end: accepts accesses, classifies them and queues them for the back end.
module shiprrip_front #(
	parameter int NUM_SETS = shiprrip_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS = shiprrip_pkg::DEF_NUM_WAYS,
	parameter int SIG_BITS = shiprrip_pkg::DEF_SIG_BITS,
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
	localparam int WAY_W = $clog2(NUM_WAYS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  shiprrip_pkg::in_item_t in_data,
	output logic                   q_valid,
	input  logic                   q_ready,
	output logic [SET_W-1:0]       q_set,
	output logic [SIG_BITS-1:0]    q_sig,
	output logic [WAY_W-1:0]       q_way,
	output shiprrip_pkg::kind_t    q_kind
);
	import shiprrip_pkg::*;

	function automatic logic [SET_W-1:0] set_reduce(input logic [9:0] s);
		logic [26:0] r;
		r = 27'(s);
		for (int k = 9; k >= 0; k--) begin
			if (r >= (27'(NUM_SETS) << k)) begin
				r = r - (27'(NUM_SETS) << k);
			end
		end
		return r[SET_W-1:0];
	endfunction

	logic [SET_W-1:0]    ent_set_q [2];
	logic [SIG_BITS-1:0] ent_sig_q [2];
	logic [WAY_W-1:0]    ent_way_q [2];
	kind_t               ent_kind_q [2];
	logic                wr_ptr_q, rd_ptr_q;
	logic [1:0]          cnt_q;
	logic                push, pop;
	logic [WAY_W+3:0]    way_ext;
	kind_t               kind_in;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign way_ext = {{WAY_W{1'b0}}, in_data.hit_way};

	always_comb begin
		if (!in_data.hit) begin
			kind_in = KIND_MISS;
		end else if (6'(in_data.hit_way) < 6'(NUM_WAYS)) begin
			kind_in = KIND_HIT;
		end else begin
			kind_in = KIND_IGNORE;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_set_q[wr_ptr_q]  <= set_reduce(in_data.set_index);
			ent_sig_q[wr_ptr_q]  <= in_data.pc[SIG_BITS+1:2];
			ent_way_q[wr_ptr_q]  <= way_ext[WAY_W-1:0];
			ent_kind_q[wr_ptr_q] <= kind_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign q_set  = ent_set_q[rd_ptr_q];
	assign q_sig  = ent_sig_q[rd_ptr_q];
	assign q_way  = ent_way_q[rd_ptr_q];
	assign q_kind = ent_kind_q[rd_ptr_q];

endmodule

FILE: design/shiprrip_back.sv
// Back end: set and counter memories, the update sequencer and the result register.
module shiprrip_back #(
	parameter int NUM_SETS  = shiprrip_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS  = shiprrip_pkg::DEF_NUM_WAYS,
	parameter int SIG_BITS  = shiprrip_pkg::DEF_SIG_BITS,
	parameter int CTR_BITS  = shiprrip_pkg::DEF_CTR_BITS,
	parameter int RRPV_BITS = shiprrip_pkg::DEF_RRPV_BITS,
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
	localparam int WAY_W = $clog2(NUM_WAYS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_ready,
	input  logic [SET_W-1:0]        q_set,
	input  logic [SIG_BITS-1:0]     q_sig,
	input  logic [WAY_W-1:0]        q_way,
	input  shiprrip_pkg::kind_t     q_kind,
	output logic                    out_valid,
	input  logic                    out_ready,
	output shiprrip_pkg::out_item_t out_data
);
	import shiprrip_pkg::*;

	localparam int SIG_N = 1 << SIG_BITS;
	localparam int CLR_N = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
	localparam int CLR_W = $clog2(CLR_N);
	localparam logic [RRPV_BITS-1:0] DIST = {RRPV_BITS{1'b1}};
	localparam logic [RRPV_BITS-1:0] NEAR = DIST - RRPV_BITS'(1);
	localparam logic [CTR_BITS-1:0] CTR_MAX = {CTR_BITS{1'b1}};

	typedef logic [NUM_WAYS-1:0][RRPV_BITS-1:0] rv_row_t;
	typedef logic [NUM_WAYS-1:0][SIG_BITS-1:0]  sg_row_t;
	typedef logic [NUM_WAYS-1:0]                ru_row_t;

	rv_row_t rv_mem [NUM_SETS];
	sg_row_t sg_mem [NUM_SETS];
	ru_row_t ru_mem [NUM_SETS];
	logic [CTR_BITS-1:0] ctr_mem [SIG_N];

	state_t state_q, state_d;
	logic [CLR_W-1:0]    clr_q;
	logic [SET_W-1:0]    set_q;
	logic [SIG_BITS-1:0] sig_q;
	logic [WAY_W-1:0]    way_q;
	kind_t               kind_q;

	rv_row_t rv_rd_q, rv_q, rv_wd, rv_aged, rv_fill;
	sg_row_t sg_rd_q, sg_q, sg_wd, sg_upd;
	ru_row_t ru_rd_q, ru_q, ru_wd, ru_upd;
	logic                row_wen, row_ren;
	logic [SET_W-1:0]    row_waddr;

	logic [CTR_BITS-1:0] ctr_rd_q, ctr_wd, nc_q, ctr_new, ctr_dec;
	logic                ctr_wen, ctr_ren;
	logic [SIG_BITS-1:0] ctr_waddr, ctr_raddr, oldsig_q;
	logic                same_q, oldreu_q;

	logic [RRPV_BITS-1:0] top;
	logic [WAY_W-1:0]     vict, victim_q;
	logic                 distant;
	logic                 clr_row, out_free, out_valid_q;
	out_item_t            res_q, out_data_q;
	logic [WAY_W+3:0]     vext;

	assign clr_row = ({1'b0, clr_q} < (CLR_W+1)'(NUM_SETS));
	assign out_free = !out_valid_q || out_ready;
	assign q_ready = (state_q == ST_IDLE);
	assign row_ren = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		top = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (rv_rd_q[w] > top) begin
				top = rv_rd_q[w];
			end
		end
		vict = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (rv_rd_q[w] == top) begin
				vict = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			rv_aged[w] = rv_rd_q[w] + (DIST - top);
		end
	end

	always_comb begin
		sg_upd       = sg_rd_q;
		sg_upd[vict] = sig_q;
		ru_upd       = ru_rd_q;
		ru_upd[vict] = 1'b0;
	end

	assign ctr_new = same_q ? nc_q : ctr_rd_q;
	assign distant = (ctr_new == '0);
	assign ctr_dec = (!oldreu_q && ctr_rd_q != '0) ? ctr_rd_q - CTR_BITS'(1) : ctr_rd_q;

	always_comb begin
		rv_fill = rv_q;
		rv_fill[victim_q] = distant ? DIST : NEAR;
	end

	always_comb begin
		row_wen   = 1'b0;
		row_waddr = set_q;
		rv_wd     = rv_fill;
		sg_wd     = sg_q;
		ru_wd     = ru_q;
		ctr_wen   = 1'b0;
		ctr_waddr = oldsig_q;
		ctr_wd    = ctr_dec;
		ctr_ren   = 1'b0;
		ctr_raddr = sg_rd_q[vict];
		state_d   = state_q;
		case (state_q)
			ST_CLEAR: begin
				row_wen   = clr_row;
				row_waddr = clr_q[SET_W-1:0];
				rv_wd     = {NUM_WAYS{DIST}};
				sg_wd     = '0;
				ru_wd     = '0;
				ctr_wen   = 1'b1;
				ctr_waddr = clr_q[SIG_BITS-1:0];
				ctr_wd    = '0;
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				if (kind_q == KIND_HIT) begin
					row_wen = 1'b1;
					rv_wd = rv_rd_q;
					rv_wd[way_q] = '0;
					sg_wd = sg_rd_q;
					ru_wd = ru_rd_q;
					ru_wd[way_q] = 1'b1;
					ctr_ren = 1'b1;
					ctr_raddr = sg_rd_q[way_q];
					state_d = ST_CTR1;
				end else if (kind_q == KIND_MISS) begin
					ctr_ren = 1'b1;
					state_d = ST_CTR1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CTR1: begin
				ctr_wen = 1'b1;
				if (kind_q == KIND_HIT) begin
					ctr_wd = (ctr_rd_q != CTR_MAX) ? ctr_rd_q + CTR_BITS'(1) : ctr_rd_q;
					state_d = ST_DONE;
				end else begin
					ctr_ren = 1'b1;
					ctr_raddr = sig_q;
					state_d = ST_CTR2;
				end
			end
			ST_CTR2: begin
				row_wen = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (row_ren) begin
			rv_rd_q <= rv_mem[q_set];
			sg_rd_q <= sg_mem[q_set];
			ru_rd_q <= ru_mem[q_set];
		end
	end

	always_ff @(posedge clk) begin
		if (row_wen) begin
			rv_mem[row_waddr] <= rv_wd;
			sg_mem[row_waddr] <= sg_wd;
			ru_mem[row_waddr] <= ru_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctr_ren) begin
			ctr_rd_q <= ctr_mem[ctr_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctr_wen) begin
			ctr_mem[ctr_waddr] <= ctr_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (row_ren) begin
			set_q  <= q_set;
			sig_q  <= q_sig;
			way_q  <= q_way;
			kind_q <= q_kind;
		end
		if (state_q == ST_ROW) begin
			rv_q <= rv_aged;
			sg_q <= sg_upd;
			ru_q <= ru_upd;
			victim_q <= vict;
			oldsig_q <= (kind_q == KIND_HIT) ? sg_rd_q[way_q] : sg_rd_q[vict];
			oldreu_q <= ru_rd_q[vict];
			res_q <= '0;
		end
		if (state_q == ST_CTR1) begin
			nc_q   <= ctr_dec;
			same_q <= (sig_q == oldsig_q);
		end
		if (state_q == ST_CTR2) begin
			res_q.victim_way     <= vext[3:0];
			res_q.filled         <= 1'b1;
			res_q.insert_distant <= distant;
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= res_q;
		end
	end

	assign vext = {4'b0, victim_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sim/tb_ship_signature_rrip_replacement.sv
// Self-checking testbench for the SHiP re-reference replacement block, with an internal predictor.
`timescale 1ns / 1ps

module tb_ship_signature_rrip_replacement;
	import shiprrip_pkg::*;

	localparam int NUM_SETS  = DEF_NUM_SETS;
	localparam int NUM_WAYS  = DEF_NUM_WAYS;
	localparam int SIG_BITS  = DEF_SIG_BITS;
	localparam int CTR_BITS  = DEF_CTR_BITS;
	localparam int RRPV_BITS = DEF_RRPV_BITS;
	localparam int LINES     = NUM_SETS * NUM_WAYS;
	localparam int SIG_COUNT = 1 << SIG_BITS;
	localparam logic [RRPV_BITS-1:0] DISTANT = '1;
	localparam logic [CTR_BITS-1:0]  CTR_TOP = '1;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	logic [RRPV_BITS-1:0] line_rrpv [LINES];
	logic [SIG_BITS-1:0]  line_sig [LINES];
	logic                 line_reused [LINES];
	logic [CTR_BITS-1:0]  sig_ctr [SIG_COUNT];

	out_item_t expected_decisions[$];
	int        error_count;
	int        access_count;
	int        decision_count;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_off_cycles;
	int        miss_count;
	int        hit_count;

	ship_signature_rrip_replacement u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic out_item_t predict_access(in_item_t acc);
		out_item_t res;
		int base;
		int line;
		int victim;
		logic [RRPV_BITS-1:0] top;
		logic [RRPV_BITS-1:0] gap;
		logic [SIG_BITS-1:0] new_sig;
		logic [SIG_BITS-1:0] old_sig;
		res = '0;
		base = (int'(acc.set_index) % NUM_SETS) * NUM_WAYS;
		new_sig = acc.pc[SIG_BITS+1:2];
		if (acc.hit) begin
			if (int'(acc.hit_way) < NUM_WAYS) begin
				line = base + int'(acc.hit_way);
				line_reused[line] = 1'b1;
				if (sig_ctr[line_sig[line]] != CTR_TOP)
					sig_ctr[line_sig[line]]++;
				line_rrpv[line] = '0;
			end
			return res;
		end
		top = '0;
		for (int w = 0; w < NUM_WAYS; w++)
			if (line_rrpv[base+w] > top)
				top = line_rrpv[base+w];
		gap = DISTANT - top;
		victim = -1;
		for (int w = 0; w < NUM_WAYS; w++) begin
			line_rrpv[base+w] = line_rrpv[base+w] + gap;
			if (victim < 0 && line_rrpv[base+w] == DISTANT)
				victim = w;
		end
		line = base + victim;
		old_sig = line_sig[line];
		if (!line_reused[line] && sig_ctr[old_sig] != '0)
			sig_ctr[old_sig]--;
		line_reused[line] = 1'b0;
		line_sig[line] = new_sig;
		res.victim_way = victim[3:0];
		res.filled = 1'b1;
		res.insert_distant = (sig_ctr[new_sig] == '0);
		line_rrpv[line] = res.insert_distant ? DISTANT : DISTANT - 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	task automatic send_access(in_item_t acc);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= acc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_decisions.push_back(predict_access(acc));
		access_count++;
		if (acc.hit) hit_count++; else miss_count++;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			decision_count++;
			if (expected_decisions.size() == 0)
				report_mismatch("unexpected transaction", 1, 0);
			else begin
				want = expected_decisions.pop_front();
				if (out_data.victim_way != want.victim_way)
					report_mismatch("victim_way", int'(out_data.victim_way),
						int'(want.victim_way));
				if (out_data.filled != want.filled)
					report_mismatch("filled", int'(out_data.filled), int'(want.filled));
				if (out_data.insert_distant != want.insert_distant)
					report_mismatch("insert_distant", int'(out_data.insert_distant),
						int'(want.insert_distant));
			end
		end
	end

	function automatic in_item_t make_access(int set_idx, bit is_hit, int way, logic [47:0] pc);
		in_item_t acc;
		acc.set_index = set_idx[9:0];
		acc.hit = is_hit;
		acc.hit_way = way[3:0];
		acc.pc = pc;
		return acc;
	endfunction

	function automatic logic [47:0] rand_pc();
		return {16'($urandom_range(65535)), $urandom()};
	endfunction

	task automatic test_directed();
		send_access(make_access(0, 1'b0, 0, '0));
		send_access(make_access(1023, 1'b0, 15, '1));
		send_access(make_access(1023, 1'b1, 0, '1));
		send_access(make_access(1023, 1'b0, 3, 48'h0000_0000_0004));
		send_access(make_access(0, 1'b1, 15, 48'hAAAA_AAAA_AAAA));
		send_access(make_access(0, 1'b1, 0, 48'h5555_5555_5555));
		for (int i = 0; i < 6; i++)
			send_access(make_access(5, 1'b0, i, 48'h0000_0000_1230));
		for (int i = 0; i < 3; i++)
			send_access(make_access(5, 1'b1, i, '0));
		for (int i = 0; i < 6; i++)
			send_access(make_access(5, 1'b0, 0, 48'h0000_0000_1230));
		for (int i = 0; i < 8; i++)
			send_access(make_access(5, 1'b1, 0, '0));
		send_access(make_access(5, 1'b0, 0, 48'h0000_0000_1230));
	endtask

	// Accesses concentrate on a few sets and signatures so counters and aging see real reuse.
	task automatic test_random(int count);
		int set_idx;
		logic [47:0] pc;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				set_idx = $urandom_range(1023);
				pc = rand_pc();
			end else begin
				set_idx = $urandom_range(7) * 131;
				pc = (rand_pc() & 48'hFFFF_FFFF_0003) | 48'($urandom_range(15) << 2);
			end
			send_access(make_access(set_idx, 1'($urandom_range(1)), $urandom_range(15), pc));
		end
	endtask

	task automatic test_backpressure();
		hold_off_cycles = 400;
		test_random(40);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_decisions.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < LINES; i++) begin
			line_rrpv[i] = DISTANT;
			line_sig[i] = '0;
			line_reused[i] = 1'b0;
		end
		for (int i = 0; i < SIG_COUNT; i++)
			sig_ctr[i] = '0;
		error_count = 0;
		access_count = 0;
		decision_count = 0;
		hit_count = 0;
		miss_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(300);
		send_idle_pct = 50;
		test_random(300);
		send_idle_pct = 0;
		recv_stall_pct = 50;
		test_random(300);
		send_idle_pct = 33;
		recv_stall_pct = 33;
		test_random(300);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		drain();

		$display("Covered %0d accesses (%0d hits, %0d misses), %0d decisions checked,",
			access_count, hit_count, miss_count, decision_count);
		$display("under mixed sender gaps, receiver stalls and a long output hold-off.");
		if (error_count == 0 && expected_decisions.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
